[rtl/core/kreq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kreq_pkg;

  typedef enum logic [1:0] {
    REQ_ROTARY = 2'd0,
    REQ_SCAN   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_ROTARY_BASE = 3'd0,
    REG_KEY_BASE    = 3'd1,
    REG_SCAN_PERIOD = 3'd2,
    REG_HOLD_THRESH = 3'd3,
    REG_READ_EN     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STEP_IDLE  = 2'd0,
    STEP_FIRST = 2'd1,
    STEP_BOTH  = 2'd2,
    STEP_LAST  = 2'd3
  } dec_step_t;

  // pin pair codes, pin_b in the upper bit
  localparam logic [1:0] BA_NONE = 2'b00;
  localparam logic [1:0] BA_A    = 2'b01;
  localparam logic [1:0] BA_B    = 2'b10;
  localparam logic [1:0] BA_AB   = 2'b11;

  localparam logic [7:0] RELEASE_FLAG = 8'h80;
  localparam logic [3:0] HOLD_MAX     = 4'd15;
  localparam int         KEY_IDX_W    = 3;
  localparam int         CFG_ADDR_W   = 5;
  localparam int         CFG_DATA_W   = 32;

  localparam logic [6:0] RST_ROTARY_BASE = 7'd0;
  localparam logic [6:0] RST_KEY_BASE    = 7'd2;
  localparam logic [7:0] RST_SCAN_PERIOD = 8'd10;
  localparam logic [7:0] RST_HOLD_THRESH = 8'd10;
  localparam logic       RST_READ_EN     = 1'b1;

  typedef struct packed {
    logic [6:0] rotary_base;
    logic [6:0] key_base;
    logic [7:0] scan_period;
    logic [7:0] hold_thresh;
    logic       read_en;
  } cfg_t;

  // one classified item on its way to the event fifo side
  typedef struct packed {
    logic       push_vld;
    logic [7:0] push_data;
    logic       rd_req;
    logic       rd_err;
    logic [7:0] cw_hits;
    logic [7:0] ccw_hits;
  } op_t;

endpackage

`default_nettype wire

[rtl/core/keypad_rotary_event_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Keypad and rotary encoder event unit. Each input transaction is a pin change, a key scan,
// a read or a no-op, and gives exactly one output transaction carrying the popped event byte
// (if any), a read error flag and both quick-repeat counters. The front end decodes and classifies
// one transaction per clock, which is also the sustained rate, while the output does not stall; a
// two-entry queue feeds the event fifo stage, which owns a single-port-per-side event store with
// registered read. Results pass the queue register and then the output register; a stalled output
// absorbs two more transactions before in_tready drops. No clearing pass is needed after reset.
module keypad_rotary_event_queue_core #(
  parameter int FIFO_DEPTH = 16,
  parameter int NUM_KEYS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // pin_a, pin_b, key_levels[7:0], now_tick[7:0]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_data[7:0], cw_repeat_count[7:0], ccw_repeat_count[7:0]
  output logic [1:0]       out_tuser,  // read_valid, read_error
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [kreq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [kreq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [kreq_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic             cfg_pready
);

  kreq_pkg::cfg_t     cfg_r;
  kreq_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  kreq_pkg::op_t f_op, q_op;
  logic          f_vld, q_in_rdy, q_vld, b_rdy;
  logic [1:0]    q_cnt;
  logic          rd_vld, rd_err;
  logic [7:0]    rd_data, cw_hits, ccw_hits;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = kreq_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotary_base <= kreq_pkg::RST_ROTARY_BASE;
      cfg_r.key_base    <= kreq_pkg::RST_KEY_BASE;
      cfg_r.scan_period <= kreq_pkg::RST_SCAN_PERIOD;
      cfg_r.hold_thresh <= kreq_pkg::RST_HOLD_THRESH;
      cfg_r.read_en     <= kreq_pkg::RST_READ_EN;
    end else if (cfg_wr) begin
      case (reg_idx)
        kreq_pkg::REG_ROTARY_BASE: cfg_r.rotary_base <= cfg_pwdata[6:0];
        kreq_pkg::REG_KEY_BASE:    cfg_r.key_base    <= cfg_pwdata[6:0];
        kreq_pkg::REG_SCAN_PERIOD: cfg_r.scan_period <= cfg_pwdata[7:0];
        kreq_pkg::REG_HOLD_THRESH: cfg_r.hold_thresh <= cfg_pwdata[7:0];
        kreq_pkg::REG_READ_EN:     cfg_r.read_en     <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kreq_pkg::REG_ROTARY_BASE: cfg_prdata = {25'd0, cfg_r.rotary_base};
      kreq_pkg::REG_KEY_BASE:    cfg_prdata = {25'd0, cfg_r.key_base};
      kreq_pkg::REG_SCAN_PERIOD: cfg_prdata = {24'd0, cfg_r.scan_period};
      kreq_pkg::REG_HOLD_THRESH: cfg_prdata = {24'd0, cfg_r.hold_thresh};
      kreq_pkg::REG_READ_EN:     cfg_prdata = {31'd0, cfg_r.read_en};
      default:                   cfg_prdata = '0;
    endcase
  end

  kreq_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_vld     (in_tvalid),
    .in_req     (in_tuser),
    .pin_a      (in_tdata[0]),
    .pin_b      (in_tdata[1]),
    .key_levels (in_tdata[9:2]),
    .now_tick   (in_tdata[17:10]),
    .q_rdy      (q_in_rdy),
    .in_rdy     (in_tready),
    .op_vld     (f_vld),
    .op         (f_op)
  );

  kreq_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .in_op   (f_op),
    .in_rdy  (q_in_rdy),
    .out_vld (q_vld),
    .out_op  (q_op),
    .out_rdy (b_rdy),
    .cnt     (q_cnt)
  );

  kreq_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_vld       (q_vld),
    .op           (q_op),
    .op_rdy       (b_rdy),
    .out_vld      (out_tvalid),
    .out_rdy      (out_tready),
    .out_rd_vld   (rd_vld),
    .out_rd_data  (rd_data),
    .out_rd_err   (rd_err),
    .out_cw_hits  (cw_hits),
    .out_ccw_hits (ccw_hits)
  );

  assign out_tdata = {ccw_hits, cw_hits, rd_data};
  assign out_tuser = {rd_err, rd_vld};

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt != 2'd3)
    else $error("op queue count out of range");

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && q_cnt == 2'd2))
    else $error("input stalled without a stalled output");

  a_read_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("read result both valid and in error");

endmodule

`default_nettype wire

[rtl/core/kreq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module kreq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/kreq_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module kreq_front #(
  parameter int NUM_KEYS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire kreq_pkg::cfg_t  cfg,
  input  wire logic            in_vld,
  input  wire logic [1:0]      in_req,
  input  wire logic            pin_a,
  input  wire logic            pin_b,
  input  wire logic [7:0]      key_levels,
  input  wire logic [7:0]      now_tick,
  input  wire logic            q_rdy,
  output logic                 in_rdy,
  output logic                 op_vld,
  output kreq_pkg::op_t        op
);

  kreq_pkg::dec_step_t step_r, step_nxt;
  logic       dir_r, dir_nxt;
  logic [7:0] cw_last_r, cw_last_nxt;
  logic [7:0] ccw_last_r, ccw_last_nxt;
  logic [7:0] cw_hits_r, cw_hits_nxt;
  logic [7:0] ccw_hits_r, ccw_hits_nxt;
  logic       busy_r, busy_nxt;
  logic [kreq_pkg::KEY_IDX_W-1:0] akey_r, akey_nxt;
  logic [3:0] hold_r, hold_nxt;
  logic [7:0] check_r, check_nxt;

  logic       acc, rot, scan, turn_done;
  logic [1:0] ba;
  logic       found;
  logic [kreq_pkg::KEY_IDX_W-1:0] fidx;
  logic [7:0] key_id, cw_dt, ccw_dt, chk_dt;
  logic       key_push;
  logic [7:0] key_data;

  assign acc    = in_vld && q_rdy;
  assign in_rdy = q_rdy;
  assign op_vld = acc;
  assign ba     = {pin_b, pin_a};
  assign rot    = acc && (in_req == kreq_pkg::REQ_ROTARY);
  assign scan   = acc && (in_req == kreq_pkg::REQ_SCAN) && cfg.read_en;

  // quadrature step sequencer
  always_comb begin
    step_nxt = step_r;
    dir_nxt  = dir_r;
    if (rot) begin
      case (step_r)
        kreq_pkg::STEP_IDLE: begin
          if (ba == kreq_pkg::BA_A) begin
            dir_nxt  = 1'b0;
            step_nxt = kreq_pkg::STEP_FIRST;
          end else if (ba == kreq_pkg::BA_B) begin
            dir_nxt  = 1'b1;
            step_nxt = kreq_pkg::STEP_FIRST;
          end
        end
        kreq_pkg::STEP_FIRST: begin
          step_nxt = (ba == kreq_pkg::BA_AB) ? kreq_pkg::STEP_BOTH : kreq_pkg::STEP_IDLE;
        end
        kreq_pkg::STEP_BOTH: begin
          if ((ba == kreq_pkg::BA_B && !dir_r) || (ba == kreq_pkg::BA_A && dir_r)) begin
            step_nxt = kreq_pkg::STEP_LAST;
          end else begin
            step_nxt = kreq_pkg::STEP_IDLE;
          end
        end
        kreq_pkg::STEP_LAST: begin
          step_nxt = kreq_pkg::STEP_IDLE;
        end
        default: begin
          step_nxt = kreq_pkg::STEP_IDLE;
        end
      endcase
    end
  end

  assign turn_done = rot && (step_r == kreq_pkg::STEP_LAST) && (ba == kreq_pkg::BA_NONE)
                     && !busy_r;

  // repeat-hit counters
  assign cw_dt  = now_tick - cw_last_r;
  assign ccw_dt = now_tick - ccw_last_r;

  always_comb begin
    cw_hits_nxt  = cw_hits_r;
    ccw_hits_nxt = ccw_hits_r;
    cw_last_nxt  = cw_last_r;
    ccw_last_nxt = ccw_last_r;
    if (turn_done && !dir_r) begin
      cw_hits_nxt = (cw_dt < cfg.scan_period) ? cw_hits_r + 8'd1 : 8'd0;
      cw_last_nxt = now_tick;
    end
    if (turn_done && dir_r) begin
      ccw_hits_nxt = (ccw_dt < cfg.scan_period) ? ccw_hits_r + 8'd1 : 8'd0;
      ccw_last_nxt = now_tick;
    end
  end

  // lowest pressed key
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (key_levels[i]) begin
        found = 1'b1;
        fidx  = kreq_pkg::KEY_IDX_W'(i);
      end
    end
  end

  assign chk_dt = now_tick - check_r;
  assign key_id = {1'b0, cfg.key_base} + {5'b0, akey_r};

  always_comb begin
    busy_nxt  = busy_r;
    akey_nxt  = akey_r;
    hold_nxt  = hold_r;
    check_nxt = check_r;
    key_push  = 1'b0;
    key_data  = key_id;
    if (scan) begin
      if (!busy_r) begin
        if (found) begin
          busy_nxt  = 1'b1;
          akey_nxt  = fidx;
          check_nxt = now_tick;
          key_push  = 1'b1;
          key_data  = {1'b0, cfg.key_base} + {5'b0, fidx};
        end
      end else if (chk_dt >= cfg.scan_period) begin
        check_nxt = now_tick;
        if (key_levels[akey_r]) begin
          if (hold_r != kreq_pkg::HOLD_MAX) begin
            hold_nxt = hold_r + 4'd1;
          end
          key_push = ({4'b0, hold_nxt} > cfg.hold_thresh);
        end else begin
          busy_nxt = 1'b0;
          hold_nxt = '0;
          key_push = 1'b1;
          key_data = key_id | kreq_pkg::RELEASE_FLAG;
        end
      end
    end
  end

  always_comb begin
    op.push_vld  = turn_done || key_push;
    op.push_data = turn_done ? ({1'b0, cfg.rotary_base} + {7'b0, dir_r}) : key_data;
    op.rd_req    = (in_req == kreq_pkg::REQ_READ) && cfg.read_en;
    op.rd_err    = (in_req == kreq_pkg::REQ_READ) && !cfg.read_en;
    op.cw_hits   = cw_hits_nxt;
    op.ccw_hits  = ccw_hits_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= kreq_pkg::STEP_IDLE;
      dir_r      <= 1'b0;
      cw_last_r  <= '0;
      ccw_last_r <= '0;
      cw_hits_r  <= '0;
      ccw_hits_r <= '0;
      busy_r     <= 1'b0;
      akey_r     <= '0;
      hold_r     <= '0;
      check_r    <= '0;
    end else begin
      step_r     <= step_nxt;
      dir_r      <= dir_nxt;
      cw_last_r  <= cw_last_nxt;
      ccw_last_r <= ccw_last_nxt;
      cw_hits_r  <= cw_hits_nxt;
      ccw_hits_r <= ccw_hits_nxt;
      busy_r     <= busy_nxt;
      akey_r     <= akey_nxt;
      hold_r     <= hold_nxt;
      check_r    <= check_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/kreq_opq.sv]
`timescale 1ns / 1ps
`default_nettype none

module kreq_opq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire kreq_pkg::op_t  in_op,
  output logic                in_rdy,
  output logic                out_vld,
  output kreq_pkg::op_t       out_op,
  input  wire logic           out_rdy,
  output logic [1:0]          cnt
);

  kreq_pkg::op_t ent_r [2];
  logic       wr_idx_r, rd_idx_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_rdy  = (cnt_r != 2'd2);
  assign out_vld = (cnt_r != 2'd0);
  assign out_op  = ent_r[rd_idx_r];
  assign cnt     = cnt_r;
  assign push    = in_vld && in_rdy;
  assign pop     = out_vld && out_rdy;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_idx_r] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_idx_r <= !wr_idx_r;
      end
      if (pop) begin
        rd_idx_r <= !rd_idx_r;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/kreq_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module kreq_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           op_vld,
  input  wire kreq_pkg::op_t  op,
  output logic                op_rdy,
  output logic                out_vld,
  input  wire logic           out_rdy,
  output logic                out_rd_vld,
  output logic [7:0]          out_rd_data,
  output logic                out_rd_err,
  output logic [7:0]          out_cw_hits,
  output logic [7:0]          out_ccw_hits
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

  logic [PTR_W-1:0] wp_r, rp_r, wp_inc, rp_inc;
  logic             fire, full, empty, we, re;
  logic [7:0]       rdata;
  logic             vld_r, rdv_r, err_r;
  logic [7:0]       cw_r, ccw_r;

  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_ONE;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + PTR_ONE;
  assign full   = (wp_inc == rp_r);
  assign empty  = (wp_r == rp_r);

  assign op_rdy = !vld_r || out_rdy;
  assign fire   = op_vld && op_rdy;
  assign we     = fire && op.push_vld && !full;
  assign re     = fire && op.rd_req && !empty;

  kreq_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (op.push_data),
    .re    (re),
    .raddr (rp_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      vld_r <= 1'b0;
    end else begin
      if (we) begin
        wp_r <= wp_inc;
      end
      if (re) begin
        rp_r <= rp_inc;
      end
      if (fire) begin
        vld_r <= 1'b1;
      end else if (out_rdy) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdv_r <= re;
      err_r <= op.rd_err;
      cw_r  <= op.cw_hits;
      ccw_r <= op.ccw_hits;
    end
  end

  assign out_vld      = vld_r;
  assign out_rd_vld   = rdv_r;
  assign out_rd_data  = rdv_r ? rdata : 8'd0;
  assign out_rd_err   = err_r;
  assign out_cw_hits  = cw_r;
  assign out_ccw_hits = ccw_r;

endmodule

`default_nettype wire
